// ----- hdl/tgeq_pkg.sv -----
// shared types, codes and reset constants of the touch gesture event queue
package tgeq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_COORD_BITS  = 12;

   localparam logic [30:0] RST_LONG_TIMEOUT  = 31'd1000000;
   localparam logic [30:0] RST_EXTRA_TIMEOUT = 31'd30000000;
   localparam logic [30:0] RST_REPEAT_DELAY  = 31'd250000;

   typedef enum logic [1:0] {
      OP_DOWN = 2'd0,
      OP_MOVE = 2'd1,
      OP_UP   = 2'd2,
      OP_POP  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_DOWN   = 3'd0,
      KIND_MOVE   = 3'd1,
      KIND_LONG   = 3'd2,
      KIND_EXTRA  = 3'd3,
      KIND_REPEAT = 3'd4,
      KIND_UP     = 3'd5
   } kind_type;

   localparam logic [1:0] CSR_LONG_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_EXTRA_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_REPEAT_DELAY  = 2'd2;

   typedef struct packed {
      logic     load;
      logic     start_touch;
      kind_type kind;
      logic     mark_long;
      logic     mark_extra;
      logic     mark_repeat;
      logic     scan_start;
      logic     scan_rd;
      logic     scan_next;
      logic     found;
      logic     shift_rd;
      logic     shift_wr;
      logic     drop;
      logic     insert;
      logic     head_rd;
      logic     pop;
      logic     respond;
   } tgeq_cmd_type;

   typedef struct packed {
      logic want_long;
      logic want_extra;
      logic want_repeat;
      logic skip;
      logic full;
      logic empty;
      logic hit_move;
      logic left_one;
   } tgeq_status_type;

endpackage

// ----- hdl/touch_gesture_event_queue_unit.sv -----
// top level of the touch gesture event queue
// Touch reports (down, move, up) and pop requests enter on the req_ stream; each
// item yields exactly one rsp_ item carrying the popped event, if any, and the
// queue fill after the item. Events live in a circular RAM of QUEUE_DEPTH
// entries, one read or write per cycle. When the queue is full, each event adds
// a scan for the oldest move, a shift of every later entry down to close the
// gap, and a drop. A stalled rsp_ side adds its wait. A new item is taken while
// the previous result still waits in the output register. Timeouts are written
// on the csr_ port; the user must write them between items only, as the block
// itself does not enforce it.
module touch_gesture_event_queue_unit #(
   parameter int QUEUE_DEPTH = tgeq_pkg::DEF_QUEUE_DEPTH,
   parameter int COORD_BITS  = tgeq_pkg::DEF_COORD_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // tdata: pos_x, pos_y, timestamp, zero fill
   input  logic [((2*COORD_BITS+32+7)/8)*8-1:0]         req_tdata,
   // tuser: opcode
   input  logic [1:0]                                   req_tuser,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // tdata: event_x, event_y, queue_fill, zero fill
   output logic [((2*COORD_BITS+5+7)/8)*8-1:0]          rsp_tdata,
   // tuser: event_valid, event_kind
   output logic [3:0]                                   rsp_tuser,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [1:0]                                   csr_index,
   input  logic [31:0]                                  csr_data
);
   import tgeq_pkg::*;

   localparam int RSP_W = ((2*COORD_BITS+5+7)/8)*8;

   tgeq_cmd_type          cmd;
   tgeq_status_type       st;
   logic                  rsp_valid_bit;
   logic [2:0]            rsp_kind;
   logic [COORD_BITS-1:0] rsp_x, rsp_y;
   logic [4:0]            rsp_fill;

   assign csr_ready = 1'b1;

   tgeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .st         (st)
   );

   tgeq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_x         (req_tdata[COORD_BITS-1:0]),
      .req_y         (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .req_ts        (req_tdata[2*COORD_BITS+31:2*COORD_BITS]),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid_bit (rsp_valid_bit),
      .rsp_kind      (rsp_kind),
      .rsp_x         (rsp_x),
      .rsp_y         (rsp_y),
      .rsp_fill      (rsp_fill)
   );

   assign rsp_tdata = RSP_W'({rsp_fill, rsp_y, rsp_x});
   assign rsp_tuser = {rsp_kind, rsp_valid_bit};

endmodule

// ----- hdl/tgeq_ram.sv -----
// generic single-port-write ram with one registered read port
module tgeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tgeq_ctrl.sv -----
// sequencer of the touch gesture event queue: event phases, evict scan, pop
module tgeq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  tgeq_pkg::op_type          req_op,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output tgeq_pkg::tgeq_cmd_type    cmd,
   input  tgeq_pkg::tgeq_status_type st
);
   import tgeq_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_EVENT    = 12'b0000_0000_0010,
      S_CHECK    = 12'b0000_0000_0100,
      S_SCAN_RD  = 12'b0000_0000_1000,
      S_SCAN_CHK = 12'b0000_0001_0000,
      S_SHIFT_RD = 12'b0000_0010_0000,
      S_SHIFT_WR = 12'b0000_0100_0000,
      S_DROP     = 12'b0000_1000_0000,
      S_INSERT   = 12'b0001_0000_0000,
      S_POP_RD   = 12'b0010_0000_0000,
      S_POP_WAIT = 12'b0100_0000_0000,
      S_FINISH   = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_LONG   = 2'd1,
      PH_EXTRA  = 2'd2,
      PH_REPEAT = 2'd3
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   kind_type  kind_ff, kind_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff;

   state_type adv_state;
   phase_type adv_phase;

   // where to go once the current event is queued or dropped
   always_comb begin
      adv_state = S_FINISH;
      adv_phase = phase_ff;
      if (op_ff == OP_MOVE) begin
         case (phase_ff)
            PH_FIRST: begin
               adv_state = S_EVENT;
               adv_phase = PH_LONG;
            end
            PH_LONG: begin
               adv_state = S_EVENT;
               adv_phase = PH_EXTRA;
            end
            PH_EXTRA: begin
               adv_state = S_EVENT;
               adv_phase = PH_REPEAT;
            end
            default: adv_state = S_FINISH;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.kind = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load        = 1'b1;
               cmd.start_touch = (req_op == OP_DOWN);
               op_in           = req_op;
               phase_in        = PH_FIRST;
               state_in        = (req_op == OP_POP) ? S_POP_RD : S_EVENT;
            end
         end
         S_EVENT: begin
            unique case (phase_ff)
               PH_FIRST: begin
                  case (op_ff)
                     OP_DOWN: kind_in = KIND_DOWN;
                     OP_MOVE: kind_in = KIND_MOVE;
                     default: kind_in = KIND_UP;
                  endcase
                  state_in = S_CHECK;
               end
               PH_LONG: begin
                  if (st.want_long) begin
                     cmd.mark_long = 1'b1;
                     kind_in       = KIND_LONG;
                     state_in      = S_CHECK;
                  end else begin
                     phase_in = PH_EXTRA;
                  end
               end
               PH_EXTRA: begin
                  if (st.want_extra) begin
                     cmd.mark_extra = 1'b1;
                     kind_in        = KIND_EXTRA;
                     state_in       = S_CHECK;
                  end else begin
                     phase_in = PH_REPEAT;
                  end
               end
               PH_REPEAT: begin
                  if (st.want_repeat) begin
                     cmd.mark_repeat = 1'b1;
                     kind_in         = KIND_REPEAT;
                     state_in        = S_CHECK;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            endcase
         end
         S_CHECK: begin
            if (st.skip) begin
               state_in = adv_state;
               phase_in = adv_phase;
            end else if (!st.full) begin
               state_in = S_INSERT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (st.hit_move) begin
               cmd.found = 1'b1;
               state_in  = st.left_one ? S_DROP : S_SHIFT_RD;
            end else if (st.left_one) begin
               // full of non-move events: the new one is lost
               state_in = adv_state;
               phase_in = adv_phase;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            cmd.shift_rd = 1'b1;
            state_in     = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = st.left_one ? S_DROP : S_SHIFT_RD;
         end
         S_DROP: begin
            cmd.drop = 1'b1;
            state_in = S_INSERT;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = adv_state;
            phase_in   = adv_phase;
         end
         S_POP_RD: begin
            if (st.empty) begin
               state_in = S_FINISH;
            end else begin
               cmd.head_rd = 1'b1;
               state_in    = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            cmd.pop  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FIRST;
         kind_ff      <= KIND_DOWN;
         op_ff        <= OP_DOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         op_ff    <= op_in;
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hdl/tgeq_dp.sv -----
// datapath: timeout compares, touch state, circular event store, result register
module tgeq_dp #(
   parameter int QUEUE_DEPTH = tgeq_pkg::DEF_QUEUE_DEPTH,
   parameter int COORD_BITS  = tgeq_pkg::DEF_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tgeq_pkg::tgeq_cmd_type    cmd,
   output tgeq_pkg::tgeq_status_type st,
   input  logic [COORD_BITS-1:0]     req_x,
   input  logic [COORD_BITS-1:0]     req_y,
   input  logic [31:0]               req_ts,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_data,
   output logic                      rsp_valid_bit,
   output logic [2:0]                rsp_kind,
   output logic [COORD_BITS-1:0]     rsp_x,
   output logic [COORD_BITS-1:0]     rsp_y,
   output logic [4:0]                rsp_fill
);
   import tgeq_pkg::*;

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W  = 2 * COORD_BITS;
   localparam int ENT_W  = 3 + POS_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);

   logic [30:0]           long_to_ff, extra_to_ff, rep_delay_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [31:0]           ts_ff, down_ff, last_rep_ff;
   logic                  long_ff, extra_ff, rep_queued_ff;
   logic [CNT_W-1:0]      count_ff, left_ff;
   logic [ADDR_W-1:0]     head_ff, tail_ff, ptr_ff;
   logic [ENT_W-1:0]      newest_ff;
   logic                  cap_valid_ff;
   logic [2:0]            cap_kind_ff;
   logic [COORD_BITS-1:0] cap_x_ff, cap_y_ff;
   logic                  out_valid_ff;
   logic [2:0]            out_kind_ff;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [4:0]            out_fill_ff;

   logic [ADDR_W-1:0] nxt_ptr, nxt_head, nxt_tail, prv_tail;
   logic [ENT_W-1:0]  new_ent, rdata, wr_data;
   logic [2:0]        rd_kind, newest_kind;
   logic              wr_en, rd_en, dup_move;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // signed 32-bit elapsed time; negative never reaches the limit
   function automatic logic reached(logic [31:0] now, logic [31:0] since,
                                    logic [30:0] limit);
      logic [31:0] d;
      d = now - since;
      return !d[31] && (d[30:0] >= limit);
   endfunction

   assign nxt_ptr  = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + ADDR_W'(1);
   assign nxt_head = (head_ff == LAST_ADDR) ? '0 : head_ff + ADDR_W'(1);
   assign nxt_tail = (tail_ff == LAST_ADDR) ? '0 : tail_ff + ADDR_W'(1);
   assign prv_tail = (tail_ff == '0) ? LAST_ADDR : tail_ff - ADDR_W'(1);

   assign new_ent     = {cmd.kind, y_ff, x_ff};
   assign rd_kind     = rdata[ENT_W-1 -: 3];
   assign newest_kind = newest_ff[ENT_W-1 -: 3];

   // a move at the same point as the newest queued entry, when that is a move, adds nothing
   assign dup_move = (cmd.kind == KIND_MOVE) && (count_ff != '0) &&
                     (newest_kind == KIND_MOVE) &&
                     (newest_ff[POS_W-1:0] == {y_ff, x_ff});

   always_comb begin
      st             = '0;
      st.want_long   = !long_ff && reached(ts_ff, down_ff, long_to_ff);
      st.want_extra  = long_ff && !extra_ff && reached(ts_ff, down_ff, extra_to_ff);
      st.want_repeat = reached(ts_ff, last_rep_ff, rep_delay_ff);
      st.skip        = ((cmd.kind == KIND_REPEAT) && rep_queued_ff) || dup_move;
      st.full        = (count_ff == CNT_W'(QUEUE_DEPTH));
      st.empty       = (count_ff == '0);
      st.hit_move    = (rd_kind == KIND_MOVE);
      st.left_one    = (left_ff == CNT_W'(1));
   end

   assign wr_en   = cmd.shift_wr | cmd.insert;
   assign wr_addr = cmd.insert ? tail_ff : ptr_ff;
   assign wr_data = cmd.insert ? new_ent : rdata;
   assign rd_en   = cmd.scan_rd | cmd.shift_rd | cmd.head_rd;
   assign rd_addr = cmd.scan_rd ? ptr_ff : (cmd.shift_rd ? nxt_ptr : head_ff);

   tgeq_ram #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         long_to_ff    <= RST_LONG_TIMEOUT;
         extra_to_ff   <= RST_EXTRA_TIMEOUT;
         rep_delay_ff  <= RST_REPEAT_DELAY;
         down_ff       <= '0;
         last_rep_ff   <= '0;
         long_ff       <= 1'b0;
         extra_ff      <= 1'b0;
         rep_queued_ff <= 1'b0;
         count_ff      <= '0;
         left_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         ptr_ff        <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_LONG_TIMEOUT:  long_to_ff   <= csr_data[30:0];
               CSR_EXTRA_TIMEOUT: extra_to_ff  <= csr_data[30:0];
               CSR_REPEAT_DELAY:  rep_delay_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         if (cmd.start_touch) begin
            down_ff     <= req_ts;
            last_rep_ff <= req_ts;
            long_ff     <= 1'b0;
            extra_ff    <= 1'b0;
         end
         if (cmd.mark_long) begin
            long_ff <= 1'b1;
         end
         if (cmd.mark_extra) begin
            extra_ff <= 1'b1;
         end
         if (cmd.mark_repeat) begin
            last_rep_ff <= ts_ff;
         end
         if (cmd.scan_start) begin
            ptr_ff  <= head_ff;
            left_ff <= count_ff;
         end
         if (cmd.scan_next || cmd.shift_wr) begin
            ptr_ff  <= nxt_ptr;
            left_ff <= left_ff - CNT_W'(1);
         end
         if (cmd.found) begin
            left_ff <= left_ff - CNT_W'(1);
         end
         if (cmd.drop) begin
            tail_ff  <= prv_tail;
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.insert) begin
            tail_ff  <= nxt_tail;
            count_ff <= count_ff + CNT_W'(1);
            if (cmd.kind == KIND_REPEAT) begin
               rep_queued_ff <= 1'b1;
            end
         end
         if (cmd.pop) begin
            head_ff  <= nxt_head;
            count_ff <= count_ff - CNT_W'(1);
            if (rd_kind == KIND_REPEAT) begin
               rep_queued_ff <= 1'b0;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff         <= req_x;
         y_ff         <= req_y;
         ts_ff        <= req_ts;
         cap_valid_ff <= 1'b0;
         cap_kind_ff  <= '0;
         cap_x_ff     <= '0;
         cap_y_ff     <= '0;
      end
      if (cmd.insert) begin
         newest_ff <= new_ent;
      end
      if (cmd.pop) begin
         cap_valid_ff <= 1'b1;
         cap_kind_ff  <= rd_kind;
         cap_x_ff     <= rdata[COORD_BITS-1:0];
         cap_y_ff     <= rdata[POS_W-1:COORD_BITS];
      end
      if (cmd.respond) begin
         out_valid_ff <= cap_valid_ff;
         out_kind_ff  <= cap_kind_ff;
         out_x_ff     <= cap_x_ff;
         out_y_ff     <= cap_y_ff;
         out_fill_ff  <= 5'(count_ff);
      end
   end

   assign rsp_valid_bit = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_x         = out_x_ff;
   assign rsp_y         = out_y_ff;
   assign rsp_fill      = out_fill_ff;

endmodule

// ----- tb/tgeq_gesture_check.sv -----
`timescale 1ns / 100ps
// watcher of the touch gesture event queue channels: predicts every response item and compares
module tgeq_gesture_check #(
   parameter int DEPTH = tgeq_pkg::DEF_QUEUE_DEPTH,
   parameter int CB    = tgeq_pkg::DEF_COORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [((2*CB+32+7)/8)*8-1:0]       req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [((2*CB+5+7)/8)*8-1:0]        rsp_tdata,
   input  logic [3:0]                         rsp_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [31:0]                        csr_data,
   output int                                 fail_count,
   output int                                 pending
);
   import tgeq_pkg::*;

   typedef struct packed {
      logic          valid;
      logic [2:0]    kind;
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic [4:0]    fill;
   } gesture_rsp_type;

   // timeouts as last written
   logic [30:0] long_limit;
   logic [30:0] extra_limit;
   logic [30:0] repeat_gap;

   // modeled event fifo, oldest entry at index 0
   kind_type      ev_kind [DEPTH];
   logic [CB-1:0] ev_x [DEPTH];
   logic [CB-1:0] ev_y [DEPTH];
   int            ev_count;

   logic [31:0] touch_start;
   logic [31:0] repeat_mark;
   bit          long_done;
   bit          extra_done;

   gesture_rsp_type expected_rsp [$];

   // elapsed time with bit 31 set is negative and never reaches a timeout
   function automatic bit elapsed_reaches(logic [31:0] now, logic [31:0] since,
                                          logic [30:0] limit);
      logic [31:0] span;
      span = now - since;
      return !span[31] && span >= {1'b0, limit};
   endfunction

   function automatic void remove_entry(int pos);
      for (int j = pos + 1; j < ev_count; j++) begin
         ev_kind[j-1] = ev_kind[j];
         ev_x[j-1]    = ev_x[j];
         ev_y[j-1]    = ev_y[j];
      end
      if (ev_count > 0) ev_count--;
   endfunction

   function automatic void queue_event(kind_type k, logic [CB-1:0] x, logic [CB-1:0] y);
      if (k == KIND_REPEAT) begin
         for (int i = 0; i < ev_count; i++)
            if (ev_kind[i] == KIND_REPEAT) return;
      end
      if (k == KIND_MOVE && ev_count > 0) begin
         if (ev_kind[ev_count-1] == KIND_MOVE && ev_x[ev_count-1] == x &&
             ev_y[ev_count-1] == y) return;
      end
      // full: evict the oldest move, if there is one
      if (ev_count >= DEPTH) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (ev_kind[i] == KIND_MOVE) begin
               remove_entry(i);
               break;
            end
         end
      end
      if (ev_count < DEPTH) begin
         ev_kind[ev_count] = k;
         ev_x[ev_count]    = x;
         ev_y[ev_count]    = y;
         ev_count++;
      end
   endfunction

   function automatic gesture_rsp_type predict_gesture(op_type op, logic [CB-1:0] x,
                                                       logic [CB-1:0] y, logic [31:0] ts);
      gesture_rsp_type r;
      r = '0;
      case (op)
         OP_DOWN: begin
            touch_start = ts;
            repeat_mark = ts;
            long_done   = 1'b0;
            extra_done  = 1'b0;
            queue_event(KIND_DOWN, x, y);
         end
         OP_MOVE: begin
            queue_event(KIND_MOVE, x, y);
            if (!long_done && elapsed_reaches(ts, touch_start, long_limit)) begin
               long_done = 1'b1;
               queue_event(KIND_LONG, x, y);
            end
            if (long_done && !extra_done && elapsed_reaches(ts, touch_start, extra_limit)) begin
               extra_done = 1'b1;
               queue_event(KIND_EXTRA, x, y);
            end
            // the mark moves on even when the repeat event is dropped
            if (elapsed_reaches(ts, repeat_mark, repeat_gap)) begin
               queue_event(KIND_REPEAT, x, y);
               repeat_mark = ts;
            end
         end
         OP_UP: queue_event(KIND_UP, x, y);
         default: begin
            if (ev_count > 0) begin
               r.valid = 1'b1;
               r.kind  = ev_kind[0];
               r.x     = ev_x[0];
               r.y     = ev_y[0];
               remove_entry(0);
            end
         end
      endcase
      r.fill = 5'(ev_count);
      return r;
   endfunction

   always @(posedge clock) begin
      gesture_rsp_type got;
      gesture_rsp_type want;
      if (reset) begin
         long_limit  = RST_LONG_TIMEOUT;
         extra_limit = RST_EXTRA_TIMEOUT;
         repeat_gap  = RST_REPEAT_DELAY;
         for (int i = 0; i < DEPTH; i++) begin
            ev_kind[i] = KIND_DOWN;
            ev_x[i]    = '0;
            ev_y[i]    = '0;
         end
         ev_count    = 0;
         touch_start = '0;
         repeat_mark = '0;
         long_done   = 1'b0;
         extra_done  = 1'b0;
         fail_count  = 0;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LONG_TIMEOUT:  long_limit  = csr_data[30:0];
               CSR_EXTRA_TIMEOUT: extra_limit = csr_data[30:0];
               CSR_REPEAT_DELAY:  repeat_gap  = csr_data[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_rsp.push_back(predict_gesture(op_type'(req_tuser), req_tdata[CB-1:0],
                                                   req_tdata[2*CB-1:CB],
                                                   req_tdata[2*CB+31:2*CB]));
         if (rsp_tvalid && rsp_tready) begin
            got.valid = rsp_tuser[0];
            got.kind  = rsp_tuser[3:1];
            got.x     = rsp_tdata[CB-1:0];
            got.y     = rsp_tdata[2*CB-1:CB];
            got.fill  = rsp_tdata[2*CB+4:2*CB];
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%t unexpected response item: valid %0d kind %0d x %0d y %0d fill %0d",
                           $realtime, got.valid, got.kind, got.x, got.y, got.fill);
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%t response mismatch: expected valid %0d kind %0d x %0d y %0d fill %0d",
                              $realtime, want.valid, want.kind, want.x, want.y, want.fill);
                     $display("%t response mismatch: got valid %0d kind %0d x %0d y %0d fill %0d",
                              $realtime, got.valid, got.kind, got.x, got.y, got.fill);
                  end
               end
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top of the touch gesture event queue: stimulus, idling and the verdict
module tb_top;
   import tgeq_pkg::*;

   localparam int CB = DEF_COORD_BITS;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic [((2*CB+32+7)/8)*8-1:0]     req_tdata = '0;
   logic [1:0]                       req_tuser = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [((2*CB+5+7)/8)*8-1:0]      rsp_tdata;
   logic [3:0]                       rsp_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [1:0]                       csr_index = '0;
   logic [31:0]                      csr_data = '0;

   int          fail_count;
   int          pending;
   logic [31:0] now_us;
   int          items_sent = 0;
   bit          src_idle_en = 1'b1;
   bit          sink_idle_en = 1'b1;
   int          sink_hold = 0;

   always #10 clock = ~clock;

   touch_gesture_event_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tgeq_gesture_check i_gesture_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // response side stalls in bursts
   always @(negedge clock) begin
      if (!sink_idle_en) begin
         rsp_tready <= 1'b1;
      end else if (sink_hold > 0) begin
         sink_hold--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         sink_hold = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [CB-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CB'($urandom());
      endcase
   endfunction

   task automatic send_report(op_type op, logic [CB-1:0] x, logic [CB-1:0] y,
                              logic [31:0] ts);
      int gap;
      if (src_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ts, y, x};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_pop();
      send_report(OP_POP, pick_coord(), pick_coord(), $urandom());
   endtask

   task automatic maybe_pop(int pop_pct);
      if ($urandom_range(0, 99) < pop_pct) send_pop();
   endtask

   // sender holds off until every response item is back
   task automatic pause_until_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [30:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= {1'($urandom_range(0, 1)), value};
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic set_timeouts(logic [30:0] long_us, logic [30:0] extra_us,
                               logic [30:0] repeat_us);
      write_reg(CSR_LONG_TIMEOUT, long_us);
      write_reg(CSR_EXTRA_TIMEOUT, extra_us);
      write_reg(CSR_REPEAT_DELAY, repeat_us);
   endtask

   // down, a run of moves and usually an up, with pops mixed in
   task automatic touch_gesture(int pop_pct, logic [31:0] step_max);
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      int            moves;
      x = pick_coord();
      y = pick_coord();
      maybe_pop(pop_pct);
      send_report(OP_DOWN, x, y, now_us);
      moves = $urandom_range(1, 12);
      for (int i = 0; i < moves; i++) begin
         maybe_pop(pop_pct);
         case ($urandom_range(0, 15))
            0: now_us -= $urandom_range(1, 1000);
            1: now_us += $urandom();
            default: now_us += $urandom_range(0, step_max);
         endcase
         // same point again now and then, to hit the duplicate move drop
         if ($urandom_range(0, 3) != 0) begin
            x = pick_coord();
            y = pick_coord();
         end
         send_report(OP_MOVE, x, y, now_us);
      end
      if ($urandom_range(0, 7) != 0) begin
         maybe_pop(pop_pct);
         now_us += $urandom_range(0, step_max);
         send_report(OP_UP, x, y, now_us);
      end
   endtask

   task automatic run_phase(int target, int pop_pct, logic [31:0] step_max, bit idling);
      int stop_at;
      stop_at = items_sent + target;
      now_us  = $urandom();
      while (items_sent < stop_at) begin
         src_idle_en  = idling && $urandom_range(0, 3) != 0;
         sink_idle_en = idling && $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 9))
            0: send_report(op_type'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                           $urandom());
            1: repeat ($urandom_range(1, 20)) send_pop();
            default: touch_gesture(pop_pct, step_max);
         endcase
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // reset timeouts: 1 s long, 30 s extra long, 250 ms repeat
      send_pop();
      send_report(OP_DOWN, 12'd0, 12'd0, 32'd0);
      send_report(OP_MOVE, 12'd4095, 12'd4095, 32'd10);
      send_report(OP_MOVE, 12'd4095, 12'd4095, 32'd20);
      send_report(OP_MOVE, 12'd4095, 12'd0, 32'd250010);
      send_report(OP_MOVE, 12'd0, 12'd4095, 32'd300000);
      send_report(OP_MOVE, 12'd1, 12'd2, 32'd600000);
      send_report(OP_MOVE, 12'd3, 12'd4, 32'd1000000);
      send_report(OP_MOVE, 12'd5, 12'd6, 32'd30000000);
      send_report(OP_MOVE, 12'd7, 12'd8, 32'hFFFF_FFF0);
      send_report(OP_UP, 12'd7, 12'd8, 32'hFFFF_FFFF);
      send_report(OP_DOWN, 12'd4095, 12'd4095, 32'hFFFF_FF00);
      send_report(OP_MOVE, 12'd9, 12'd9, 32'h0000_0100);
      send_report(OP_UP, 12'd9, 12'd9, 32'h0000_0200);
      send_report(OP_UP, 12'd9, 12'd9, 32'h0000_0300);
      send_report(OP_DOWN, 12'd0, 12'd4095, 32'h0000_0400);
      send_report(OP_MOVE, 12'd10, 12'd11, 32'h0000_0500);
      repeat (3) send_pop();
      run_phase(250, 55, 32'd300000, 1'b1);

      pause_until_drained();
      set_timeouts(31'd60, 31'd250, 31'd25);
      run_phase(300, 35, 32'd40, 1'b1);

      pause_until_drained();
      set_timeouts('0, '0, '0);
      run_phase(250, 70, 32'd10, 1'b1);

      // all-ones timeouts are reached only at an elapsed time of exactly that value
      pause_until_drained();
      set_timeouts('1, '1, '1);
      send_report(OP_DOWN, 12'd100, 12'd200, 32'h0000_0100);
      send_report(OP_MOVE, 12'd101, 12'd201, 32'h8000_00FE);
      send_report(OP_MOVE, 12'd102, 12'd202, 32'h8000_00FF);
      run_phase(250, 55, 32'hFFFF_FFFF, 1'b1);

      pause_until_drained();
      set_timeouts(31'($urandom_range(0, 200)), 31'($urandom_range(0, 800)),
                   31'($urandom_range(0, 60)));
      run_phase(300, 50, 32'd50, 1'b0);

      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("touch_gesture_event_queue_unit verification clean");
      else
         $display("touch_gesture_event_queue_unit verification failed");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("touch_gesture_event_queue_unit verification failed");
      $finish;
   end

endmodule
